@@ design/clock_string_field_parser_macros.svh @@
// Assertion helpers shared by the clock reply parser
`ifndef CLOCK_STRING_FIELD_PARSER_MACROS_SVH
`define CLOCK_STRING_FIELD_PARSER_MACROS_SVH

// Same-cycle implication, checked on clk outside reset
`define CPSF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk outside reset
`define CPSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/cpsf_pkg.sv @@
package cpsf_pkg;

    // Default number of characters counted per field
    localparam int FIELD_CHARS_DEF = 4;

    localparam int ACC_W = 14;
    localparam logic [ACC_W-1:0] ACC_MAX = 14'd9999;
    localparam logic [ACC_W-1:0] YEAR_BASE = 14'd2000;
    localparam logic [15:0] MIN_LEN = 16'd16;

    localparam logic [ACC_W-1:0] MONTH_MAX = 14'd12;
    localparam logic [ACC_W-1:0] DAY_MAX = 14'd31;
    localparam logic [ACC_W-1:0] HOUR_MAX = 14'd24;
    localparam logic [ACC_W-1:0] MINUTE_MAX = 14'd60;
    localparam logic [ACC_W-1:0] SECOND_MAX = 14'd60;

    // Field currently being parsed
    typedef enum logic [2:0] {
        PH_YEAR,
        PH_MONTH,
        PH_DAY,
        PH_HOUR,
        PH_MINUTE,
        PH_SECOND
    } phase_t;

    // One character of the reply
    typedef struct packed {
        logic [7:0]  char_in;
        logic        start_req;
        logic        last;
        logic [15:0] msg_len;
    } in_word_t;

    // One parsed time stamp
    typedef struct packed {
        logic        status;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } out_word_t;

    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Separator that closes each field
    function automatic logic [7:0] separator_of(input phase_t ph);
        logic [7:0] sep;
        case (ph)
            PH_YEAR, PH_MONTH:    sep = 8'h2F;   // '/'
            PH_DAY:               sep = 8'h2C;   // ','
            PH_HOUR, PH_MINUTE:   sep = 8'h3A;   // ':'
            default:              sep = 8'h22;   // closing quote
        endcase
        return sep;
    endfunction

    // Error word: status set, every field zero
    function automatic out_word_t error_word();
        out_word_t w;
        w = '0;
        w.status = STATUS_ERR;
        return w;
    endfunction

endpackage

@@ design/cpsf_in_stage.sv @@
module cpsf_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               char_valid,
    output logic               char_stall,
    input  cpsf_pkg::in_word_t char_word,
    input  logic               adv,
    output logic               s1_valid,
    output cpsf_pkg::in_word_t s1_word
);

    logic               s1_valid_reg;
    logic               s1_valid_next;
    cpsf_pkg::in_word_t s1_word_reg;
    logic               load;

    // Hold off the sender only while a word waits and cannot move on
    assign char_stall = s1_valid_reg & ~adv;
    assign load       = char_valid & ~char_stall;

    always_comb
    begin
        if (load)
            s1_valid_next = 1'b1;
        else if (adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // Payload register, no reset
    always_ff @(posedge clk)
    begin
        if (load)
            s1_word_reg <= char_word;
    end

    assign s1_valid = s1_valid_reg;
    assign s1_word  = s1_word_reg;

endmodule

@@ design/cpsf_parse.sv @@
module cpsf_parse #(
    parameter int FIELD_CHARS = cpsf_pkg::FIELD_CHARS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  cpsf_pkg::in_word_t  word,
    output logic                has_res,
    output cpsf_pkg::out_word_t res
);

    localparam int CNT_W = $clog2(FIELD_CHARS + 1);
    localparam int AW = cpsf_pkg::ACC_W;

    cpsf_pkg::phase_t phase_reg, phase_next, phase_eff;
    logic [AW-1:0]    acc_reg, acc_next, acc_eff;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_eff;
    logic             stop_reg, stop_next, stop_eff;
    logic             done_reg, done_next, done_eff;
    logic [AW-1:0]    year_reg, month_reg, day_reg, hour_reg, minute_reg;
    logic [AW-1:0]    year_next, month_next, day_next, hour_next, minute_next;

    logic             short_len;
    logic             is_sep;
    logic             is_digit;
    logic [AW+3:0]    acc_mul;
    logic [AW+3:0]    acc_sum;
    logic             range_ok;

    // Start word clears the field state before the character is looked at
    always_comb
    begin
        if (word.start_req)
        begin
            phase_eff = cpsf_pkg::PH_YEAR;
            acc_eff   = '0;
            cnt_eff   = '0;
            stop_eff  = 1'b0;
            done_eff  = 1'b0;
        end
        else
        begin
            phase_eff = phase_reg;
            acc_eff   = acc_reg;
            cnt_eff   = cnt_reg;
            stop_eff  = stop_reg;
            done_eff  = done_reg;
        end
    end

    assign short_len = word.start_req && (word.msg_len < cpsf_pkg::MIN_LEN);
    assign is_sep    = (word.char_in == cpsf_pkg::separator_of(phase_eff));
    assign is_digit  = (word.char_in >= 8'h30) && (word.char_in <= 8'h39);

    // acc * 10 + digit, saturated below
    assign acc_mul = {acc_eff, 3'b000} + {1'b0, acc_eff, 1'b0};
    assign acc_sum = acc_mul + {{(AW+4-4){1'b0}}, word.char_in[3:0]};

    assign range_ok = (month_reg <= cpsf_pkg::MONTH_MAX) && (day_reg <= cpsf_pkg::DAY_MAX)
                   && (hour_reg <= cpsf_pkg::HOUR_MAX) && (minute_reg <= cpsf_pkg::MINUTE_MAX)
                   && (acc_eff <= cpsf_pkg::SECOND_MAX);

    // Next field
    always_comb
    begin
        phase_next = phase_reg;
        if (go && !short_len && !done_eff)
        begin
            phase_next = phase_eff;
            if (is_sep)
            begin
                unique case (phase_eff)
                    cpsf_pkg::PH_YEAR:   phase_next = cpsf_pkg::PH_MONTH;
                    cpsf_pkg::PH_MONTH:  phase_next = cpsf_pkg::PH_DAY;
                    cpsf_pkg::PH_DAY:    phase_next = cpsf_pkg::PH_HOUR;
                    cpsf_pkg::PH_HOUR:   phase_next = cpsf_pkg::PH_MINUTE;
                    cpsf_pkg::PH_MINUTE: phase_next = cpsf_pkg::PH_SECOND;
                    default:             phase_next = phase_eff;
                endcase
            end
        end
        else if (go)
            phase_next = phase_eff;
    end

    // Field accumulation, stores and result
    always_comb
    begin
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        stop_next   = stop_reg;
        done_next   = done_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        has_res     = 1'b0;
        res         = cpsf_pkg::error_word();

        if (go)
        begin
            acc_next  = acc_eff;
            cnt_next  = cnt_eff;
            stop_next = stop_eff;
            done_next = done_eff;

            if (short_len)
            begin
                has_res   = 1'b1;
                done_next = 1'b1;
            end
            else if (!done_eff)
            begin
                if (is_sep)
                begin
                    acc_next  = '0;
                    cnt_next  = '0;
                    stop_next = 1'b0;
                    unique case (phase_eff)
                        cpsf_pkg::PH_YEAR:   year_next   = acc_eff;
                        cpsf_pkg::PH_MONTH:  month_next  = acc_eff;
                        cpsf_pkg::PH_DAY:    day_next    = acc_eff;
                        cpsf_pkg::PH_HOUR:   hour_next   = acc_eff;
                        cpsf_pkg::PH_MINUTE: minute_next = acc_eff;
                        default:
                        begin
                            // closing quote: the reply ends here whatever last says
                            has_res   = 1'b1;
                            done_next = 1'b1;
                            if (range_ok)
                            begin
                                res.status = cpsf_pkg::STATUS_OK;
                                res.year   = year_reg + cpsf_pkg::YEAR_BASE;
                                res.month  = month_reg[3:0];
                                res.day    = day_reg[4:0];
                                res.hour   = hour_reg[4:0];
                                res.minute = minute_reg[5:0];
                                res.second = acc_eff[5:0];
                            end
                        end
                    endcase
                end
                else if (cnt_eff < CNT_W'(FIELD_CHARS))
                begin
                    cnt_next = cnt_eff + 1'b1;
                    if (!stop_eff)
                    begin
                        if (is_digit)
                        begin
                            if (acc_sum > {4'b0000, cpsf_pkg::ACC_MAX})
                                acc_next = cpsf_pkg::ACC_MAX;
                            else
                                acc_next = acc_sum[AW-1:0];
                        end
                        else
                            stop_next = 1'b1;
                    end
                end

                // last byte without the quote
                if (word.last && !(is_sep && phase_eff == cpsf_pkg::PH_SECOND))
                begin
                    has_res   = 1'b1;
                    done_next = 1'b1;
                    res       = cpsf_pkg::error_word();
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= cpsf_pkg::PH_YEAR;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            stop_reg   <= 1'b0;
            done_reg   <= 1'b1;
            year_reg   <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            stop_reg   <= stop_next;
            done_reg   <= done_next;
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
        end
    end

endmodule

@@ design/cpsf_out_stage.sv @@
module cpsf_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cpsf_pkg::out_word_t push_word,
    output logic                adv,
    output logic                stamp_valid,
    input  logic                stamp_stall,
    output cpsf_pkg::out_word_t stamp_word
);

    logic                stamp_valid_reg;
    logic                stamp_valid_next;
    cpsf_pkg::out_word_t stamp_word_reg;

    // Register may take a new word when empty or being emptied
    assign adv = ~stamp_valid_reg | ~stamp_stall;

    always_comb
    begin
        if (adv)
            stamp_valid_next = push;
        else
            stamp_valid_next = stamp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stamp_valid_reg <= 1'b0;
        else
            stamp_valid_reg <= stamp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv && push)
            stamp_word_reg <= push_word;
    end

    assign stamp_valid = stamp_valid_reg;
    assign stamp_word  = stamp_word_reg;

endmodule

@@ design/clock_string_field_parser.sv @@
// Clock reply parser.
// Input channel (char_valid / char_stall / char_word) carries one reply character
// per word, with start_req on the first character, last on the final one and the
// declared length alongside. Output channel (stamp_valid / stamp_stall /
// stamp_word) carries one time stamp per reply: status 0 with the fields, or
// status 1 with all fields zero.
// Throughput: one character per cycle while the result register can accept (char_stall
// low); the field update between the input register and the result register is combinational.
// Path: the character that ends the reply is taken into the input register, then
// parsed from the input register into the result register, whose output is
// stamp_valid.
// Characters in mid-field give no output word unless last is set.
// Reset: both registers empty, parser idle; bytes are ignored until start_req.
// Stall: a stalled result holds in the output register; if the input register
// is empty one more character is taken into it, then char_stall rises until
// the result is taken.
module clock_string_field_parser #(
    parameter int FIELD_CHARS = cpsf_pkg::FIELD_CHARS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_valid,
    output logic                char_stall,
    input  cpsf_pkg::in_word_t  char_word,
    output logic                stamp_valid,
    input  logic                stamp_stall,
    output cpsf_pkg::out_word_t stamp_word
);

    `include "clock_string_field_parser_macros.svh"

    logic                adv;
    logic                s1_valid;
    cpsf_pkg::in_word_t  s1_word;
    logic                go;
    logic                has_res;
    cpsf_pkg::out_word_t res;

    cpsf_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_word  (char_word),
        .adv        (adv),
        .s1_valid   (s1_valid),
        .s1_word    (s1_word)
    );

    // Parse a character only when its result has somewhere to go
    assign go = s1_valid & adv;

    cpsf_parse #(
        .FIELD_CHARS (FIELD_CHARS)
    ) u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go),
        .word    (s1_word),
        .has_res (has_res),
        .res     (res)
    );

    cpsf_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (go & has_res),
        .push_word   (res),
        .adv         (adv),
        .stamp_valid (stamp_valid),
        .stamp_stall (stamp_stall),
        .stamp_word  (stamp_word)
    );

    // Checks
    `CPSF_ASSERT_IMPL(a_err_zero, stamp_valid && stamp_word.status,
        stamp_word.year == 14'd0 && stamp_word.month == 4'd0 && stamp_word.day == 5'd0 &&
        stamp_word.hour == 5'd0 && stamp_word.minute == 6'd0 && stamp_word.second == 6'd0,
        "error word with nonzero field")
    `CPSF_ASSERT_IMPL(a_ok_range, stamp_valid && !stamp_word.status,
        stamp_word.year >= 14'd2000 && stamp_word.month <= 4'd12 && stamp_word.day <= 5'd31 &&
        stamp_word.hour <= 5'd24 && stamp_word.minute <= 6'd60 && stamp_word.second <= 6'd60,
        "ok word out of range")
    `CPSF_ASSERT_IMPL(a_stall_full, char_stall, s1_valid, "input stalled with empty register")
    `CPSF_ASSERT_NEXT(a_hold_word, s1_valid && !adv, s1_valid, "waiting character dropped")

endmodule
